// ===== sv/obb_pkg.sv =====
// Shared widths and stage record types for the oriented box overlap test.
// No dependencies; used by every module under sv/.
package obb_pkg;

    localparam int PosW      = 24;   // Q15.8 centre
    localparam int AxW       = 16;   // Q1.14 axis component
    localparam int SzW       = 23;   // Q15.8 full size
    localparam int DiffW     = PosW + 1;
    localparam int AxProdW   = 2 * AxW;          // axis x axis product
    localparam int CosW      = 2 * AxW;          // |cos|, |sin| magnitudes, up to 2^31
    localparam int DProdW    = DiffW + AxW;      // centre difference x axis
    localparam int DMagW     = DProdW;           // |d . L| fits below 2^40
    localparam int ExtW      = CosW + SzW;       // projected extent term
    localparam int BoundW    = ExtW + 1;         // sum of extents plus own size
    localparam int DistShift = 15;
    localparam int OwnShift  = 28;
    localparam int InDataW   = 256;
    localparam int OutDataW  = 8;

    typedef struct packed {
        logic signed [PosW-1:0] first_center_x;
        logic signed [PosW-1:0] first_center_y;
        logic signed [AxW-1:0]  first_axis_x;
        logic signed [AxW-1:0]  first_axis_y;
        logic [SzW-1:0]         first_width;
        logic [SzW-1:0]         first_height;
        logic signed [PosW-1:0] second_center_x;
        logic signed [PosW-1:0] second_center_y;
        logic signed [AxW-1:0]  second_axis_x;
        logic signed [AxW-1:0]  second_axis_y;
        logic [SzW-1:0]         second_width;
        logic [SzW-1:0]         second_height;
    } pair_t;

    // after stage 1: centre difference and the four axis cross products
    typedef struct packed {
        logic signed [DiffW-1:0]   dx;
        logic signed [DiffW-1:0]   dy;
        logic signed [AxW-1:0]     r1x;
        logic signed [AxW-1:0]     r1y;
        logic signed [AxW-1:0]     r2x;
        logic signed [AxW-1:0]     r2y;
        logic signed [AxProdW-1:0] pxx;   // r1x * r2x
        logic signed [AxProdW-1:0] pyy;   // r1y * r2y
        logic signed [AxProdW-1:0] pxy;   // r1x * r2y
        logic signed [AxProdW-1:0] pyx;   // r1y * r2x
        logic [SzW-1:0]            w1;
        logic [SzW-1:0]            h1;
        logic [SzW-1:0]            w2;
        logic [SzW-1:0]            h2;
    } s1_t;

    // after stage 2: |r1.r2|, |r1 x r2| and the eight distance products
    typedef struct packed {
        logic [CosW-1:0]          c;
        logic [CosW-1:0]          s;
        logic signed [DProdW-1:0] dxr1x;
        logic signed [DProdW-1:0] dyr1y;
        logic signed [DProdW-1:0] dxr1y;
        logic signed [DProdW-1:0] dyr1x;
        logic signed [DProdW-1:0] dxr2x;
        logic signed [DProdW-1:0] dyr2y;
        logic signed [DProdW-1:0] dxr2y;
        logic signed [DProdW-1:0] dyr2x;
        logic [SzW-1:0]           w1;
        logic [SzW-1:0]           h1;
        logic [SzW-1:0]           w2;
        logic [SzW-1:0]           h2;
    } s2_t;

    // after stage 3: projected distances and extent terms
    typedef struct packed {
        logic [DMagW-1:0] d1;
        logic [DMagW-1:0] d2;
        logic [DMagW-1:0] d3;
        logic [DMagW-1:0] d4;
        logic [ExtW-1:0]  sh2;
        logic [ExtW-1:0]  cw2;
        logic [ExtW-1:0]  ch2;
        logic [ExtW-1:0]  sw2;
        logic [ExtW-1:0]  sh1;
        logic [ExtW-1:0]  cw1;
        logic [ExtW-1:0]  ch1;
        logic [ExtW-1:0]  sw1;
        logic [SzW-1:0]   w1;
        logic [SzW-1:0]   h1;
        logic [SzW-1:0]   w2;
        logic [SzW-1:0]   h2;
    } s3_t;

    // after stage 4: distance and bound per axis
    typedef struct packed {
        logic [DMagW-1:0]  d1;
        logic [DMagW-1:0]  d2;
        logic [DMagW-1:0]  d3;
        logic [DMagW-1:0]  d4;
        logic [BoundW-1:0] b1;
        logic [BoundW-1:0] b2;
        logic [BoundW-1:0] b3;
        logic [BoundW-1:0] b4;
    } s4_t;

endpackage

// ===== sv/obb_front.sv =====
// Stage 1: centre difference and axis cross products.
// Depends on obb_pkg.
module obb_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  obb_pkg::pair_t in_pair,
    output logic          out_valid,
    input  logic          out_ready,
    output obb_pkg::s1_t  out_data
);

    logic         v_reg;
    obb_pkg::s1_t s1_reg;
    obb_pkg::s1_t s1_next;

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_data  = s1_reg;

    always_comb begin
        s1_next.dx  = obb_pkg::DiffW'(in_pair.first_center_x)
                    - obb_pkg::DiffW'(in_pair.second_center_x);
        s1_next.dy  = obb_pkg::DiffW'(in_pair.first_center_y)
                    - obb_pkg::DiffW'(in_pair.second_center_y);
        s1_next.r1x = in_pair.first_axis_x;
        s1_next.r1y = in_pair.first_axis_y;
        s1_next.r2x = in_pair.second_axis_x;
        s1_next.r2y = in_pair.second_axis_y;
        s1_next.pxx = in_pair.first_axis_x * in_pair.second_axis_x;
        s1_next.pyy = in_pair.first_axis_y * in_pair.second_axis_y;
        s1_next.pxy = in_pair.first_axis_x * in_pair.second_axis_y;
        s1_next.pyx = in_pair.first_axis_y * in_pair.second_axis_x;
        s1_next.w1  = in_pair.first_width;
        s1_next.h1  = in_pair.first_height;
        s1_next.w2  = in_pair.second_width;
        s1_next.h2  = in_pair.second_height;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            s1_reg <= s1_next;
        end
    end

endmodule

// ===== sv/obb_project.sv =====
// Stages 2 and 3: axis relations, distance projections and extent products.
// Depends on obb_pkg.
module obb_project (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  obb_pkg::s1_t in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output obb_pkg::s3_t out_data
);

    logic         v2_reg;
    logic         v3_reg;
    logic         rdy2;
    logic         rdy3;
    obb_pkg::s2_t s2_reg;
    obb_pkg::s2_t s2_next;
    obb_pkg::s3_t s3_reg;
    obb_pkg::s3_t s3_next;

    logic signed [obb_pkg::CosW:0]     cos_sum;
    logic signed [obb_pkg::CosW:0]     sin_sum;
    logic [obb_pkg::CosW:0]            cos_mag;
    logic [obb_pkg::CosW:0]            sin_mag;
    logic signed [obb_pkg::DProdW:0]   p1;
    logic signed [obb_pkg::DProdW:0]   p2;
    logic signed [obb_pkg::DProdW:0]   p3;
    logic signed [obb_pkg::DProdW:0]   p4;
    logic [obb_pkg::DProdW:0]          m1;
    logic [obb_pkg::DProdW:0]          m2;
    logic [obb_pkg::DProdW:0]          m3;
    logic [obb_pkg::DProdW:0]          m4;

    assign rdy3      = !v3_reg || out_ready;
    assign rdy2      = !v2_reg || rdy3;
    assign in_ready  = rdy2;
    assign out_valid = v3_reg;
    assign out_data  = s3_reg;

    // stage 2
    always_comb begin
        cos_sum = (obb_pkg::CosW+1)'(in_data.pxx) + (obb_pkg::CosW+1)'(in_data.pyy);
        sin_sum = (obb_pkg::CosW+1)'(in_data.pxy) - (obb_pkg::CosW+1)'(in_data.pyx);
        cos_mag = (cos_sum < 0) ? -cos_sum : cos_sum;
        sin_mag = (sin_sum < 0) ? -sin_sum : sin_sum;
        s2_next.c     = cos_mag[obb_pkg::CosW-1:0];
        s2_next.s     = sin_mag[obb_pkg::CosW-1:0];
        s2_next.dxr1x = in_data.dx * in_data.r1x;
        s2_next.dyr1y = in_data.dy * in_data.r1y;
        s2_next.dxr1y = in_data.dx * in_data.r1y;
        s2_next.dyr1x = in_data.dy * in_data.r1x;
        s2_next.dxr2x = in_data.dx * in_data.r2x;
        s2_next.dyr2y = in_data.dy * in_data.r2y;
        s2_next.dxr2y = in_data.dx * in_data.r2y;
        s2_next.dyr2x = in_data.dy * in_data.r2x;
        s2_next.w1    = in_data.w1;
        s2_next.h1    = in_data.h1;
        s2_next.w2    = in_data.w2;
        s2_next.h2    = in_data.h2;
    end

    // stage 3: right and up axes of each box
    always_comb begin
        p1 = (obb_pkg::DProdW+1)'(s2_reg.dxr1x) + (obb_pkg::DProdW+1)'(s2_reg.dyr1y);
        p2 = (obb_pkg::DProdW+1)'(s2_reg.dyr1x) - (obb_pkg::DProdW+1)'(s2_reg.dxr1y);
        p3 = (obb_pkg::DProdW+1)'(s2_reg.dxr2x) + (obb_pkg::DProdW+1)'(s2_reg.dyr2y);
        p4 = (obb_pkg::DProdW+1)'(s2_reg.dyr2x) - (obb_pkg::DProdW+1)'(s2_reg.dxr2y);
        m1 = (p1 < 0) ? -p1 : p1;
        m2 = (p2 < 0) ? -p2 : p2;
        m3 = (p3 < 0) ? -p3 : p3;
        m4 = (p4 < 0) ? -p4 : p4;
        s3_next.d1  = m1[obb_pkg::DMagW-1:0];
        s3_next.d2  = m2[obb_pkg::DMagW-1:0];
        s3_next.d3  = m3[obb_pkg::DMagW-1:0];
        s3_next.d4  = m4[obb_pkg::DMagW-1:0];
        s3_next.sh2 = obb_pkg::ExtW'(s2_reg.s) * obb_pkg::ExtW'(s2_reg.h2);
        s3_next.cw2 = obb_pkg::ExtW'(s2_reg.c) * obb_pkg::ExtW'(s2_reg.w2);
        s3_next.ch2 = obb_pkg::ExtW'(s2_reg.c) * obb_pkg::ExtW'(s2_reg.h2);
        s3_next.sw2 = obb_pkg::ExtW'(s2_reg.s) * obb_pkg::ExtW'(s2_reg.w2);
        s3_next.sh1 = obb_pkg::ExtW'(s2_reg.s) * obb_pkg::ExtW'(s2_reg.h1);
        s3_next.cw1 = obb_pkg::ExtW'(s2_reg.c) * obb_pkg::ExtW'(s2_reg.w1);
        s3_next.ch1 = obb_pkg::ExtW'(s2_reg.c) * obb_pkg::ExtW'(s2_reg.h1);
        s3_next.sw1 = obb_pkg::ExtW'(s2_reg.s) * obb_pkg::ExtW'(s2_reg.w1);
        s3_next.w1  = s2_reg.w1;
        s3_next.h1  = s2_reg.h1;
        s3_next.w2  = s2_reg.w2;
        s3_next.h2  = s2_reg.h2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy2) begin
                v2_reg <= in_valid;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && in_valid) begin
            s2_reg <= s2_next;
        end
        if (rdy3 && v2_reg) begin
            s3_reg <= s3_next;
        end
    end

endmodule

// ===== sv/obb_decide.sv =====
// Stages 4 and 5: per-axis bounds, comparison and the registered verdict.
// Depends on obb_pkg.
module obb_decide (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  obb_pkg::s3_t in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         out_overlap
);

    logic         v4_reg;
    logic         v5_reg;
    logic         rdy4;
    logic         rdy5;
    obb_pkg::s4_t s4_reg;
    obb_pkg::s4_t s4_next;
    logic         overlap_reg;
    logic         overlap_next;

    logic [obb_pkg::BoundW-1:0] dist1;
    logic [obb_pkg::BoundW-1:0] dist2;
    logic [obb_pkg::BoundW-1:0] dist3;
    logic [obb_pkg::BoundW-1:0] dist4;

    assign rdy5        = !v5_reg || out_ready;
    assign rdy4        = !v4_reg || rdy5;
    assign in_ready    = rdy4;
    assign out_valid   = v5_reg;
    assign out_overlap = overlap_reg;

    // stage 4: other box extents plus own full size, all doubled
    always_comb begin
        s4_next.d1 = in_data.d1;
        s4_next.d2 = in_data.d2;
        s4_next.d3 = in_data.d3;
        s4_next.d4 = in_data.d4;
        s4_next.b1 = obb_pkg::BoundW'(in_data.sh2) + obb_pkg::BoundW'(in_data.cw2)
                   + (obb_pkg::BoundW'(in_data.w1) << obb_pkg::OwnShift);
        s4_next.b2 = obb_pkg::BoundW'(in_data.ch2) + obb_pkg::BoundW'(in_data.sw2)
                   + (obb_pkg::BoundW'(in_data.h1) << obb_pkg::OwnShift);
        s4_next.b3 = obb_pkg::BoundW'(in_data.sh1) + obb_pkg::BoundW'(in_data.cw1)
                   + (obb_pkg::BoundW'(in_data.w2) << obb_pkg::OwnShift);
        s4_next.b4 = obb_pkg::BoundW'(in_data.ch1) + obb_pkg::BoundW'(in_data.sw1)
                   + (obb_pkg::BoundW'(in_data.h2) << obb_pkg::OwnShift);
    end

    // stage 5: strictly greater on any axis separates; touching overlaps
    always_comb begin
        dist1 = obb_pkg::BoundW'(s4_reg.d1) << obb_pkg::DistShift;
        dist2 = obb_pkg::BoundW'(s4_reg.d2) << obb_pkg::DistShift;
        dist3 = obb_pkg::BoundW'(s4_reg.d3) << obb_pkg::DistShift;
        dist4 = obb_pkg::BoundW'(s4_reg.d4) << obb_pkg::DistShift;
        overlap_next = !((dist1 > s4_reg.b1) || (dist2 > s4_reg.b2)
                      || (dist3 > s4_reg.b3) || (dist4 > s4_reg.b4));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy4) begin
                v4_reg <= in_valid;
            end
            if (rdy5) begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && in_valid) begin
            s4_reg <= s4_next;
        end
        if (rdy5 && v4_reg) begin
            overlap_reg <= overlap_next;
        end
    end

endmodule

// ===== sv/oriented_box_overlap_test.sv =====
// Top level of the oriented box overlap test: stream ports and stage chain.
// Depends on obb_pkg, obb_front, obb_project and obb_decide.

// Each request carries two oriented rectangles (centre Q15.8, unit right axis
// Q1.14, full width and height Q15.8) and yields exactly one result: overlap is
// 1 when none of the four box axes separates them, 0 otherwise; boxes that just
// touch count as overlapping. All arithmetic is exact. The block is a
// five-stage pipeline (difference and axis products, distance products and
// axis relations, extent products, bounds, compare) and takes one request per
// clock. m_tvalid rises once the request has passed through every stage in
// that order and its verdict is registered in the compare stage. Every stage
// holds its own valid bit and fills bubbles during a stall, so s_tready drops
// only once all five stages hold requests and the result at the output is not
// being taken. The critical path is one 32 x 23 multiply in the extent stage.
// No state survives between requests; reset only empties the pipeline.
module oriented_box_overlap_test (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [23:0] first_center_x, [47:24] first_center_y, [63:48] first_axis_x,
    // [79:64] first_axis_y, [102:80] first_width, [125:103] first_height,
    // [149:126] second_center_x, [173:150] second_center_y,
    // [189:174] second_axis_x, [205:190] second_axis_y,
    // [228:206] second_width, [251:229] second_height, rest zero
    input  logic [obb_pkg::InDataW-1:0]   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] overlap, rest zero
    output logic [obb_pkg::OutDataW-1:0]  m_tdata
);

    obb_pkg::pair_t pair;
    obb_pkg::s1_t   s1;
    obb_pkg::s3_t   s3;
    logic           v1;
    logic           r1;
    logic           v3;
    logic           r3;
    logic           overlap;

    // unpack the request, lowest field first
    assign pair.first_center_x  = s_tdata[23:0];
    assign pair.first_center_y  = s_tdata[47:24];
    assign pair.first_axis_x    = s_tdata[63:48];
    assign pair.first_axis_y    = s_tdata[79:64];
    assign pair.first_width     = s_tdata[102:80];
    assign pair.first_height    = s_tdata[125:103];
    assign pair.second_center_x = s_tdata[149:126];
    assign pair.second_center_y = s_tdata[173:150];
    assign pair.second_axis_x   = s_tdata[189:174];
    assign pair.second_axis_y   = s_tdata[205:190];
    assign pair.second_width    = s_tdata[228:206];
    assign pair.second_height   = s_tdata[251:229];

    obb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pair   (pair),
        .out_valid (v1),
        .out_ready (r1),
        .out_data  (s1)
    );

    obb_project u_project (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1),
        .in_ready  (r1),
        .in_data   (s1),
        .out_valid (v3),
        .out_ready (r3),
        .out_data  (s3)
    );

    obb_decide u_decide (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (v3),
        .in_ready    (r3),
        .in_data     (s3),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_overlap (overlap)
    );

    // verdict in bit 0, padding above
    assign m_tdata = {{(obb_pkg::OutDataW-1){1'b0}}, overlap};

`ifndef NO_ASSERTIONS
    // back-pressure only when stages 1, 3 and 5 are occupied and the output is stalled
    a_full_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1 && v3 && m_tvalid && !m_tready))
        else $error("input stalled with a bubble in the pipeline");

    // an accepted request lands in the first stage
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> v1)
        else $error("accepted request not held in stage 1");

    // a waiting result stays offered and unchanged until taken
    a_hold_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("waiting result dropped or changed");

    // the internal ready chain never refuses while the output stage is empty
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid) |-> (r3 && r1 && s_tready))
        else $error("pipeline stalled with an empty output");
`endif

endmodule
